FILE: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a property, clocked and disabled during reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion on a condition that holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, (cond))

`endif

FILE: sv/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

  localparam int unsigned LevelWidth = 17;
  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [LevelWidth-1:0] Q_ONE = 17'h10000;
  localparam logic [LevelWidth-1:0] END_THRESHOLD_RESET = 17'd16;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_TRIGGER = 2'd1,
    REQ_RELEASE = 2'd2
  } req_type_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_ATTACK_COEFF  = 3'd0,
    CFG_DECAY_COEFF   = 3'd1,
    CFG_RELEASE_COEFF = 3'd2,
    CFG_SUSTAIN_LEVEL = 3'd3,
    CFG_END_THRESHOLD = 3'd4
  } cfg_index_e;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ATTACK  = 5'b00010,
    ST_DECAY   = 5'b00100,
    ST_SUSTAIN = 5'b01000,
    ST_RELEASE = 5'b10000
  } stage_e;

  localparam logic [2:0] STAGE_CODE_IDLE    = 3'd0;
  localparam logic [2:0] STAGE_CODE_ATTACK  = 3'd1;
  localparam logic [2:0] STAGE_CODE_DECAY   = 3'd2;
  localparam logic [2:0] STAGE_CODE_SUSTAIN = 3'd3;
  localparam logic [2:0] STAGE_CODE_RELEASE = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic       one_shot;
  } adsr_in_t;

  typedef struct packed {
    logic [LevelWidth-1:0] level;
    logic [2:0]            stage;
  } adsr_out_t;

  function automatic logic [LevelWidth-1:0] sat_one(input logic [LevelWidth-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

  function automatic logic [2:0] stage_code(input stage_e st);
    logic [2:0] code;
    case (st)
      ST_ATTACK:  code = STAGE_CODE_ATTACK;
      ST_DECAY:   code = STAGE_CODE_DECAY;
      ST_SUSTAIN: code = STAGE_CODE_SUSTAIN;
      ST_RELEASE: code = STAGE_CODE_RELEASE;
      default:    code = STAGE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/adsr_pole_step.sv
`timescale 1ns / 1ps

module adsr_pole_step import adsr_pkg::*; (
  input  logic [LevelWidth-1:0] level_i,
  input  logic [LevelWidth-1:0] target_i,
  input  logic [LevelWidth-1:0] coeff_i,
  output logic [LevelWidth-1:0] level_o
);

  logic                      below;
  logic [LevelWidth-1:0]     diff;
  logic [LevelWidth-1:0]     coeff_sat;
  logic [2*LevelWidth-1:0]   prod;
  logic [LevelWidth:0]       raw_step;
  logic [LevelWidth-1:0]     step;

  always_comb begin
    below     = level_i < target_i;
    diff      = below ? (target_i - level_i) : (level_i - target_i);
    coeff_sat = sat_one(coeff_i);
    prod      = {{LevelWidth{1'b0}}, diff} * {{LevelWidth{1'b0}}, coeff_sat};
    raw_step  = prod[2*LevelWidth-1:16];
    if (raw_step == '0) begin
      raw_step = {{LevelWidth{1'b0}}, 1'b1};
    end
    if (raw_step > {1'b0, diff}) begin
      step = diff;
    end else begin
      step = raw_step[LevelWidth-1:0];
    end
    if (level_i == target_i) begin
      level_o = level_i;
    end else if (below) begin
      level_o = level_i + step;
    end else begin
      level_o = level_i - step;
    end
  end

endmodule

FILE: sv/adsr_envelope_generator.sv
`timescale 1ns / 1ps
// A tick transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless a tick waits on a stalled result;
// the envelope state updates in the single step stage.
// Reset: asynchronous, active low; stage idle, level zero, one-shot clear,
// registers at their defaults, no result pending.

module adsr_envelope_generator import adsr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  adsr_in_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output adsr_out_t                out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [LevelWidth-1:0]    cfg_data_i
);

  logic [LevelWidth-1:0] attack_coeff_q;
  logic [LevelWidth-1:0] decay_coeff_q;
  logic [LevelWidth-1:0] release_coeff_q;
  logic [LevelWidth-1:0] sustain_level_q;
  logic [LevelWidth-1:0] end_threshold_q;

  logic                  in_valid_q, in_valid_d;
  adsr_in_t              in_data_q, in_data_d;
  stage_e                stage_q, stage_d;
  logic [LevelWidth-1:0] level_q, level_d;
  logic                  one_shot_q, one_shot_d;
  logic                  out_valid_q, out_valid_d;
  adsr_out_t             out_data_q, out_data_d;

  logic                  out_ready;
  logic                  is_tick;
  logic                  fire;
  logic [LevelWidth-1:0] sustain_sat;
  logic [LevelWidth-1:0] step_target;
  logic [LevelWidth-1:0] step_coeff;
  logic [LevelWidth-1:0] stepped;
  logic [LevelWidth:0]   attack_sum;
  logic [LevelWidth-1:0] decay_dist;
  logic [LevelWidth-1:0] out_level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_coeff_q  <= Q_ONE;
      decay_coeff_q   <= Q_ONE;
      release_coeff_q <= Q_ONE;
      sustain_level_q <= '0;
      end_threshold_q <= END_THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ATTACK_COEFF:  attack_coeff_q  <= cfg_data_i;
        CFG_DECAY_COEFF:   decay_coeff_q   <= cfg_data_i;
        CFG_RELEASE_COEFF: release_coeff_q <= cfg_data_i;
        CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data_i;
        CFG_END_THRESHOLD: end_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign is_tick    = in_data_q.req_type == REQ_TICK;
  assign fire       = in_valid_q && (!is_tick || out_ready);
  assign in_stall_o = in_valid_q && !fire;

  always_comb begin
    in_valid_d = in_valid_q;
    in_data_d  = in_data_q;
    if (!in_valid_q || fire) begin
      in_valid_d = in_valid_i;
      in_data_d  = in_data_i;
    end
  end

  assign sustain_sat = sat_one(sustain_level_q);

  always_comb begin
    case (stage_q)
      ST_ATTACK: begin
        step_target = Q_ONE;
        step_coeff  = attack_coeff_q;
      end
      ST_DECAY: begin
        step_target = sustain_sat;
        step_coeff  = decay_coeff_q;
      end
      default: begin
        step_target = '0;
        step_coeff  = release_coeff_q;
      end
    endcase
  end

  adsr_pole_step u_step (
    .level_i  (level_q),
    .target_i (step_target),
    .coeff_i  (step_coeff),
    .level_o  (stepped)
  );

  assign attack_sum = {1'b0, stepped} + {1'b0, end_threshold_q};
  assign decay_dist = (stepped > sustain_sat) ? (stepped - sustain_sat)
                                              : (sustain_sat - stepped);

  always_comb begin
    stage_d    = stage_q;
    level_d    = level_q;
    one_shot_d = one_shot_q;
    out_level  = '0;
    if (fire) begin
      case (in_data_q.req_type)
        REQ_TRIGGER: begin
          stage_d    = ST_ATTACK;
          one_shot_d = in_data_q.one_shot;
        end
        REQ_RELEASE: begin
          stage_d = ST_RELEASE;
        end
        REQ_TICK: begin
          case (stage_q)
            ST_ATTACK: begin
              level_d = stepped;
              if (attack_sum >= {1'b0, Q_ONE}) begin
                level_d = Q_ONE;
                stage_d = ST_DECAY;
              end
            end
            ST_DECAY: begin
              level_d = stepped;
              if (decay_dist <= end_threshold_q) begin
                if (one_shot_q) begin
                  level_d = '0;
                  stage_d = ST_IDLE;
                end else begin
                  level_d = sustain_sat;
                  stage_d = ST_SUSTAIN;
                end
              end
            end
            ST_SUSTAIN: begin
              level_d = level_q;
            end
            ST_RELEASE: begin
              level_d = stepped;
              if (stepped <= end_threshold_q) begin
                level_d = '0;
                stage_d = ST_IDLE;
              end
            end
            default: begin
              stage_d = ST_IDLE;
            end
          endcase
          out_level = (stage_q == ST_IDLE) ? '0 : level_d;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (fire && is_tick) begin
      out_valid_d      = 1'b1;
      out_data_d.level = out_level;
      out_data_d.stage = stage_code(stage_d);
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      stage_q     <= ST_IDLE;
      level_q     <= '0;
      one_shot_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      stage_q     <= stage_d;
      level_q     <= level_d;
      one_shot_q  <= one_shot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_data_q  <= in_data_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/adsr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adsr_checker import adsr_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input adsr_in_t                 in_data_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input adsr_out_t                out_data_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [CfgIndexWidth-1:0] cfg_index_i,
  input logic [LevelWidth-1:0]    cfg_data_i
);

  logic out_idle;
  logic out_attack;
  logic unused_inputs;

  assign out_idle   = out_data_o.stage == STAGE_CODE_IDLE;
  assign out_attack = out_data_o.stage == STAGE_CODE_ATTACK;
  assign unused_inputs = ^{in_valid_i, in_stall_o, in_data_i, cfg_valid_i, cfg_ready_o,
                           cfg_index_i, cfg_data_i};

  // An idle result always reports silence.
  `ASSERT_PROP(a_idle_level_zero, clk_i, rst_ni, out_valid_o && out_idle |-> out_data_o.level == '0)

  // The level never goes above full scale.
  `ASSERT_PROP(a_level_in_range, clk_i, rst_ni, out_valid_o |-> out_data_o.level <= Q_ONE)

  // Reaching full scale always ends the attack stage.
  `ASSERT_PROP(a_attack_below_full, clk_i, rst_ni, out_valid_o && out_attack |-> out_data_o.level != Q_ONE)

  // A stalled result transaction is held unchanged.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  `ASSERT_ALWAYS(a_unused_known, clk_i, rst_ni, unused_inputs == 1'b0 || unused_inputs == 1'b1)

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import adsr_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 56;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [LevelWidth-1:0] FIELD_MAX = '1;

  class envelope_scoreboard;
    logic [LevelWidth-1:0] attack_rate;
    logic [LevelWidth-1:0] decay_rate;
    logic [LevelWidth-1:0] release_rate;
    logic [LevelWidth-1:0] sustain_target;
    logic [LevelWidth-1:0] end_margin;
    logic [2:0]            stage_q;
    logic [LevelWidth-1:0] level_q;
    logic                  one_shot_q;
    adsr_out_t             expected_q[$];
    int unsigned           error_count;

    function new();
      attack_rate    = Q_ONE;
      decay_rate     = Q_ONE;
      release_rate   = Q_ONE;
      sustain_target = '0;
      end_margin     = END_THRESHOLD_RESET;
      stage_q        = STAGE_CODE_IDLE;
      level_q        = '0;
      one_shot_q     = 1'b0;
      error_count    = 0;
    endfunction

    function void write_register(logic [CfgIndexWidth-1:0] idx, logic [LevelWidth-1:0] val);
      case (idx)
        CFG_ATTACK_COEFF:  attack_rate = val;
        CFG_DECAY_COEFF:   decay_rate = val;
        CFG_RELEASE_COEFF: release_rate = val;
        CFG_SUSTAIN_LEVEL: sustain_target = val;
        CFG_END_THRESHOLD: end_margin = val;
        default: ;
      endcase
    endfunction

    // One-pole move toward a target: at least one LSB, never past the target.
    function logic [LevelWidth-1:0] glide(logic [LevelWidth-1:0] from,
                                          logic [LevelWidth-1:0] to,
                                          logic [LevelWidth-1:0] rate);
      logic [LevelWidth-1:0]   gap;
      logic [LevelWidth-1:0]   ratio;
      logic [2*LevelWidth-1:0] prod;
      logic [LevelWidth-1:0]   stride;
      if (from == to) return from;
      gap = (from < to) ? to - from : from - to;
      ratio = (rate > Q_ONE) ? Q_ONE : rate;
      prod = gap * ratio;
      stride = prod[LevelWidth+15:16];
      if (stride == '0) stride = LevelWidth'(1);
      if (stride > gap) stride = gap;
      return (from < to) ? from + stride : from - stride;
    endfunction

    function void note_request(adsr_in_t req);
      adsr_out_t             res;
      logic [LevelWidth-1:0] target;
      logic [LevelWidth-1:0] offset;
      case (req.req_type)
        REQ_TRIGGER: begin
          stage_q = STAGE_CODE_ATTACK;
          one_shot_q = req.one_shot;
          return;
        end
        REQ_RELEASE: begin
          stage_q = STAGE_CODE_RELEASE;
          return;
        end
        REQ_TICK: ;
        default: return;
      endcase
      case (stage_q)
        STAGE_CODE_ATTACK: begin
          level_q = glide(level_q, Q_ONE, attack_rate);
          if (32'(level_q) + 32'(end_margin) >= 32'(Q_ONE)) begin
            level_q = Q_ONE;
            stage_q = STAGE_CODE_DECAY;
          end
          res.level = level_q;
        end
        STAGE_CODE_DECAY: begin
          target = (sustain_target > Q_ONE) ? Q_ONE : sustain_target;
          level_q = glide(level_q, target, decay_rate);
          offset = (level_q > target) ? level_q - target : target - level_q;
          if (offset <= end_margin) begin
            if (one_shot_q) begin
              level_q = '0;
              stage_q = STAGE_CODE_IDLE;
            end else begin
              level_q = target;
              stage_q = STAGE_CODE_SUSTAIN;
            end
          end
          res.level = level_q;
        end
        STAGE_CODE_SUSTAIN: res.level = level_q;
        STAGE_CODE_RELEASE: begin
          level_q = glide(level_q, '0, release_rate);
          if (level_q <= end_margin) begin
            level_q = '0;
            stage_q = STAGE_CODE_IDLE;
          end
          res.level = level_q;
        end
        default: begin
          stage_q = STAGE_CODE_IDLE;
          res.level = '0;
        end
      endcase
      res.stage = stage_q;
      expected_q.push_back(res);
    endfunction

    function void check_result(adsr_out_t got);
      adsr_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, level %0d stage %0d", $time, got.level, got.stage);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.level !== want.level) begin
        $display("%0t: level mismatch, expected %0d, actual %0d", $time, want.level, got.level);
        error_count++;
      end
      if (got.stage !== want.stage) begin
        $display("%0t: stage mismatch, expected %0d, actual %0d", $time, want.stage, got.stage);
        error_count++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  adsr_in_t                 in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  adsr_out_t                out_data_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [LevelWidth-1:0]    cfg_data_i = '0;

  envelope_scoreboard envelope_sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  adsr_envelope_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      envelope_sb.check_result(out_data_o);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [LevelWidth-1:0] pick_rate();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return LevelWidth'($urandom_range(32'(FIELD_MAX), 32'(Q_ONE) + 1));
    if (r < 30) return Q_ONE;
    return LevelWidth'($urandom_range(32'(Q_ONE) - 1, 4000));
  endfunction

  task automatic drive_request(logic [1:0] kind, logic os);
    adsr_in_t req;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i <= adsr_in_t'($urandom);
      @(posedge clk_i);
    end
    req.req_type = kind;
    req.one_shot = os;
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    envelope_sb.note_request(req);
  endtask

  task automatic write_cfg(logic [CfgIndexWidth-1:0] idx, logic [LevelWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    envelope_sb.write_register(idx, val);
  endtask

  // A trigger or release transaction may still be in flight once the last
  // result is in, so the bench keeps waiting before the block is reconfigured.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (envelope_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned           phase_items;
    int unsigned           r;
    int unsigned           spare_idx;
    logic [1:0]            kind;
    logic [LevelWidth-1:0] sustain_pick;
    logic [LevelWidth-1:0] margin_pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_request(REQ_TICK, 1'b1);
    drive_request(REQ_UNUSED, 1'b0);
    drive_request(REQ_RELEASE, 1'b1);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TRIGGER, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TICK, 1'b1);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_RELEASE, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TRIGGER, 1'b1);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TICK, 1'b1);
    settle();

    write_cfg(CFG_ATTACK_COEFF, FIELD_MAX);
    write_cfg(CFG_DECAY_COEFF, '0);
    write_cfg(CFG_RELEASE_COEFF, Q_ONE);
    write_cfg(CFG_SUSTAIN_LEVEL, Q_ONE - LevelWidth'(1));
    write_cfg(CFG_END_THRESHOLD, '0);
    cfg_valid_i <= 1'b0;

    drive_request(REQ_TRIGGER, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TRIGGER, 1'b1);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_RELEASE, 1'b0);
    drive_request(REQ_TICK, 1'b0);
    drive_request(REQ_TRIGGER, 1'b0);
    drive_request(REQ_RELEASE, 1'b1);
    drive_request(REQ_TICK, 1'b1);
    settle();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 78; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 78; end
        default: begin send_idle_pct = 14; recv_idle_pct = 14; end
      endcase

      if (p == 2) begin
        write_cfg(CFG_ATTACK_COEFF, FIELD_MAX);
        write_cfg(CFG_DECAY_COEFF, FIELD_MAX);
        write_cfg(CFG_RELEASE_COEFF, FIELD_MAX);
        write_cfg(CFG_SUSTAIN_LEVEL, FIELD_MAX);
        write_cfg(CFG_END_THRESHOLD, FIELD_MAX);
      end else if (p == 5) begin
        write_cfg(CFG_ATTACK_COEFF, '0);
        write_cfg(CFG_DECAY_COEFF, '0);
        write_cfg(CFG_RELEASE_COEFF, '0);
        write_cfg(CFG_SUSTAIN_LEVEL, '0);
        write_cfg(CFG_END_THRESHOLD, '0);
      end else begin
        r = $urandom_range(99);
        if (r < 10) sustain_pick = '0;
        else if (r < 20) sustain_pick = Q_ONE;
        else if (r < 30) begin
          sustain_pick = LevelWidth'($urandom_range(32'(FIELD_MAX), 32'(Q_ONE) + 1));
        end
        else sustain_pick = LevelWidth'($urandom_range(32'(Q_ONE)));
        r = $urandom_range(99);
        if (r < 10) margin_pick = '0;
        else if (r < 20) margin_pick = LevelWidth'($urandom_range(32'(FIELD_MAX)));
        else margin_pick = LevelWidth'($urandom_range(2000, 1));
        write_cfg(CFG_ATTACK_COEFF, pick_rate());
        write_cfg(CFG_DECAY_COEFF, pick_rate());
        write_cfg(CFG_RELEASE_COEFF, pick_rate());
        write_cfg(CFG_SUSTAIN_LEVEL, sustain_pick);
        write_cfg(CFG_END_THRESHOLD, margin_pick);
      end
      spare_idx = $urandom_range((1 << CfgIndexWidth) - 1, int'(CFG_END_THRESHOLD) + 1);
      write_cfg(spare_idx[CfgIndexWidth-1:0], LevelWidth'($urandom_range(32'(FIELD_MAX))));
      cfg_valid_i <= 1'b0;

      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 82) begin
          drive_request(REQ_TRIGGER, 1'($urandom_range(1)));
          r = $urandom_range(30, 1);
          repeat (r) drive_request(REQ_TICK, 1'($urandom_range(1)));
          phase_items += r + 1;
          if ($urandom_range(4) != 0) begin
            drive_request(REQ_RELEASE, 1'($urandom_range(1)));
            r = $urandom_range(15);
            repeat (r) drive_request(REQ_TICK, 1'($urandom_range(1)));
            phase_items += r + 1;
          end
        end else begin
          kind = 2'($urandom_range(3));
          drive_request(kind, 1'($urandom_range(1)));
          if (kind != REQ_UNUSED) phase_items++;
        end
      end
      settle();
    end

    if (envelope_sb.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/adsr_pkg.sv
sv/adsr_pole_step.sv
sv/adsr_envelope_generator.sv
sv/adsr_checker.sv
bench/tb_top.sv
